// ===== hw/rtl/lpe_pkg.sv =====
package lpe_pkg;

	localparam int BYTE_W    = 8;
	localparam int WORD_W    = 24;
	localparam int DUTY_W    = 16;
	localparam int LEVEL_W   = 6;
	localparam int SLOT_W    = 7;
	localparam int SLOT_CNT_W = 6;
	localparam int FACTOR_W  = 17;
	localparam int PROD_W    = BYTE_W + FACTOR_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(45);
	localparam logic [SLOT_W-1:0]  MAX_SLOTS = SLOT_W'(64);
	localparam logic [SLOT_W-1:0]  MIN_SLOTS = SLOT_W'(1);

	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_EN  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LVL = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_DUTY   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_DUTY  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_SLOTS = CFG_IDX_W'(4);

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_EOF   = 1'b1;

	typedef struct packed {
		logic                bright_en;
		logic [LEVEL_W-1:0]  bright_lvl;
		logic [DUTY_W-1:0]   one_duty;
		logic [DUTY_W-1:0]   zero_duty;
		logic [SLOT_W-1:0]   reset_slots;
	} lpe_cfg_t;

	typedef struct packed {
		logic               eof;
		logic [WORD_W-1:0]  word;
	} lpe_entry_t;

	// tan(k degrees) in unsigned Q1.16, rounded
	function automatic logic [FACTOR_W-1:0] tan_q16(input logic [LEVEL_W-1:0] lvl);
		logic [FACTOR_W-1:0] f;
		case (lvl)
			6'd0:  f = 17'd0;
			6'd1:  f = 17'd1144;
			6'd2:  f = 17'd2289;
			6'd3:  f = 17'd3435;
			6'd4:  f = 17'd4583;
			6'd5:  f = 17'd5734;
			6'd6:  f = 17'd6888;
			6'd7:  f = 17'd8047;
			6'd8:  f = 17'd9210;
			6'd9:  f = 17'd10380;
			6'd10: f = 17'd11556;
			6'd11: f = 17'd12739;
			6'd12: f = 17'd13930;
			6'd13: f = 17'd15130;
			6'd14: f = 17'd16340;
			6'd15: f = 17'd17560;
			6'd16: f = 17'd18792;
			6'd17: f = 17'd20036;
			6'd18: f = 17'd21294;
			6'd19: f = 17'd22566;
			6'd20: f = 17'd23853;
			6'd21: f = 17'd25157;
			6'd22: f = 17'd26478;
			6'd23: f = 17'd27818;
			6'd24: f = 17'd29179;
			6'd25: f = 17'd30560;
			6'd26: f = 17'd31964;
			6'd27: f = 17'd33392;
			6'd28: f = 17'd34846;
			6'd29: f = 17'd36327;
			6'd30: f = 17'd37837;
			6'd31: f = 17'd39378;
			6'd32: f = 17'd40951;
			6'd33: f = 17'd42560;
			6'd34: f = 17'd44205;
			6'd35: f = 17'd45889;
			6'd36: f = 17'd47615;
			6'd37: f = 17'd49385;
			6'd38: f = 17'd51202;
			6'd39: f = 17'd53070;
			6'd40: f = 17'd54991;
			6'd41: f = 17'd56970;
			6'd42: f = 17'd59009;
			6'd43: f = 17'd61113;
			6'd44: f = 17'd63287;
			default: f = 17'd65536;
		endcase
		return f;
	endfunction

endpackage

// ===== hw/rtl/lpe_if.sv =====
interface lpe_pix_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output command, output red, output green, output blue,
		input ready);
	modport sink (input valid, input command, input red, input green, input blue,
		output ready);
endinterface

interface lpe_code_if;
	logic        valid;
	logic        ready;
	logic [15:0] duty_code;
	logic        last;

	modport source (output valid, output duty_code, output last, input ready);
	modport sink (input valid, input duty_code, input last, output ready);
endinterface

// ===== hw/rtl/led_pixel_pwm_encoder.sv =====
// channel | dir | handshake     | payload
// pix     | in  | valid / ready | command, red, green, blue
// code    | out | valid / ready | duty_code, last
// cfg     | in  | cfg_we        | cfg_index, cfg_wdata
//
// A pixel gives 24 codes, one per cycle from the back serializer unless code
// stalls; an end of frame gives reset_slots zero codes. The next item is loaded
// as the previous one emits its final code, so items follow back to back.
// An item passes the front stage register, the queue and the back serializer.
// arst_n clears control state and loads register defaults. A stall on code
// holds the output register; the two-entry queue lets intake continue meanwhile.
module led_pixel_pwm_encoder #(
	parameter int MAX_PIXELS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	lpe_pix_if.sink     pix,
	lpe_code_if.source  code,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import lpe_pkg::*;

	lpe_cfg_t          cfg_q;
	logic              q_ready;
	logic              q_push;
	lpe_entry_t        q_wdata;
	logic              q_valid;
	logic              q_pop;
	lpe_entry_t        q_rdata;
	logic [LEVEL_W-1:0] wr_lvl;
	logic [SLOT_W-1:0]  wr_slots;

	assign wr_lvl   = cfg_wdata[LEVEL_W-1:0];
	assign wr_slots = cfg_wdata[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bright_en   <= 1'b0;
			cfg_q.bright_lvl  <= MAX_LEVEL;
			cfg_q.one_duty    <= DUTY_W'(40);
			cfg_q.zero_duty   <= DUTY_W'(20);
			cfg_q.reset_slots <= SLOT_W'(50);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BRIGHT_EN:   cfg_q.bright_en <= cfg_wdata[0];
				CFG_BRIGHT_LVL:  cfg_q.bright_lvl <= (wr_lvl > MAX_LEVEL) ? MAX_LEVEL : wr_lvl;
				CFG_ONE_DUTY:    cfg_q.one_duty <= cfg_wdata;
				CFG_ZERO_DUTY:   cfg_q.zero_duty <= cfg_wdata;
				CFG_RESET_SLOTS: begin
					if (wr_slots < MIN_SLOTS) begin
						cfg_q.reset_slots <= MIN_SLOTS;
					end else if (wr_slots > MAX_SLOTS) begin
						cfg_q.reset_slots <= MAX_SLOTS;
					end else begin
						cfg_q.reset_slots <= wr_slots;
					end
				end
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	lpe_front #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.pix     (pix),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	lpe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.ready  (q_ready),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	lpe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.code    (code)
	);

endmodule

// ===== hw/rtl/lpe_front.sv =====
module lpe_front #(
	parameter int MAX_PIXELS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lpe_pkg::lpe_cfg_t cfg,
	lpe_pix_if.sink           pix,
	input  logic              q_ready,
	output logic              q_push,
	output lpe_pkg::lpe_entry_t q_wdata
);
	import lpe_pkg::*;

	localparam int CNT_W = $clog2(MAX_PIXELS + 1);

	logic [CNT_W-1:0]  pixel_count_q;
	logic              valid_s1;
	logic              cmd_s1;
	logic [BYTE_W-1:0] red_s1;
	logic [BYTE_W-1:0] green_s1;
	logic [BYTE_W-1:0] blue_s1;
	logic              take;
	logic              keep;
	logic [FACTOR_W-1:0] factor;
	logic [PROD_W-1:0] prod_r;
	logic [PROD_W-1:0] prod_g;
	logic [PROD_W-1:0] prod_b;

	assign pix.ready = !valid_s1 || q_ready;
	assign take      = pix.valid && pix.ready;
	assign keep      = (pix.command == CMD_EOF) || (pixel_count_q < CNT_W'(MAX_PIXELS));
	assign q_push    = valid_s1 && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			pixel_count_q <= '0;
		end else begin
			if (take && keep) begin
				valid_s1 <= 1'b1;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
			if (take) begin
				if (pix.command == CMD_EOF) begin
					pixel_count_q <= '0;
				end else if (keep) begin
					pixel_count_q <= pixel_count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && keep) begin
			cmd_s1   <= pix.command;
			red_s1   <= pix.red;
			green_s1 <= pix.green;
			blue_s1  <= pix.blue;
		end
	end

	// unity factor when scaling is off
	assign factor = cfg.bright_en ? tan_q16(cfg.bright_lvl) : FACTOR_W'(65536);
	assign prod_r = PROD_W'(red_s1) * PROD_W'(factor);
	assign prod_g = PROD_W'(green_s1) * PROD_W'(factor);
	assign prod_b = PROD_W'(blue_s1) * PROD_W'(factor);

	always_comb begin
		q_wdata.eof  = cmd_s1;
		q_wdata.word = {prod_g[23:16], prod_r[23:16], prod_b[23:16]};
	end

endmodule

// ===== hw/rtl/lpe_queue.sv =====
module lpe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lpe_pkg::lpe_entry_t wdata,
	output logic                ready,
	input  logic                pop,
	output logic                valid,
	output lpe_pkg::lpe_entry_t rdata
);
	import lpe_pkg::*;

	lpe_entry_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign ready = (cnt_q != 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/lpe_back.sv =====
module lpe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lpe_pkg::lpe_cfg_t   cfg,
	input  logic                q_valid,
	input  lpe_pkg::lpe_entry_t q_rdata,
	output logic                q_pop,
	lpe_code_if.source          code
);
	import lpe_pkg::*;

	logic                  busy_q;
	logic                  eof_q;
	logic [WORD_W-1:0]     word_q;
	logic [SLOT_CNT_W-1:0] slot_q;
	logic                  out_valid_q;
	logic [DUTY_W-1:0]     out_code_q;
	logic                  out_last_q;
	logic                  advance;
	logic                  emit;
	logic                  final_slot;
	logic [SLOT_W-1:0]     gap_len;

	assign advance    = !out_valid_q || code.ready;
	assign emit       = busy_q && advance;
	assign final_slot = (slot_q == '0);
	assign q_pop      = q_valid && (!busy_q || (emit && final_slot));
	assign gap_len    = cfg.reset_slots - MIN_SLOTS;

	assign code.valid     = out_valid_q;
	assign code.duty_code = out_code_q;
	assign code.last      = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= emit;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (emit && final_slot) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_last_q <= final_slot;
			if (eof_q) begin
				out_code_q <= '0;
			end else begin
				out_code_q <= word_q[WORD_W-1] ? cfg.one_duty : cfg.zero_duty;
			end
		end
		if (q_pop) begin
			eof_q  <= q_rdata.eof;
			word_q <= q_rdata.word;
			slot_q <= q_rdata.eof ? gap_len[SLOT_CNT_W-1:0] : SLOT_CNT_W'(WORD_W - 1);
		end else if (emit) begin
			word_q <= {word_q[WORD_W-2:0], 1'b0};
			slot_q <= slot_q - SLOT_CNT_W'(1);
		end
	end

endmodule

// ===== hw/rtl/lpe_checker.sv =====
module lpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        code_valid,
	input logic        code_ready,
	input logic [15:0] duty_code,
	input logic        last
);

	logic [6:0] run_q;
	logic       xfer;

	assign xfer = code_valid && code_ready;

	// count transfers since the last marked code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (xfer) begin
			run_q <= last ? 7'd0 : run_q + 7'd1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && !code_ready |=> code_valid && $stable(duty_code) && $stable(last))
		else $error("code payload changed during stall");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !code_valid)
		else $error("code valid right after reset");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |-> run_q < 7'd64)
		else $error("more than 64 codes without last");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && (run_q == 7'd63) |-> last)
		else $error("64th code of an item not marked last");

endmodule

bind led_pixel_pwm_encoder lpe_checker u_lpe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.code_valid (code.valid),
	.code_ready (code.ready),
	.duty_code  (code.duty_code),
	.last       (code.last)
);
